FILE: rtl/core/cdiv_pkg.sv
// ----------------------------------------------------------------------------
// cdiv_pkg
// Shared types, constants and the output saturation function of the complex
// divider.
// ----------------------------------------------------------------------------
`default_nettype none

package cdiv_pkg;

    localparam int OUT_WIDTH = 32;
    // quotient bits resolved by the divide stages; the top one flags a part above 2^32-1
    localparam int Q_BITS    = OUT_WIDTH + 1;

    localparam logic [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic neg_re;
        logic neg_im;
        logic dz;
        logic big_re;
        logic big_im;
    } t_flags;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] value;
        logic                 ovf;
    } t_part;

    // sign, clamp and flag one quotient part
    function automatic t_part saturate(input logic neg, input logic big,
                                       input logic [Q_BITS-1:0] q);
        t_part r;
        logic  hit;
        hit = big | q[Q_BITS-1] |
              (q[OUT_WIDTH-1] & (~neg | (|q[OUT_WIDTH-2:0])));
        r.ovf = hit;
        if (hit) begin
            r.value = neg ? OUT_MIN : OUT_MAX;
        end else begin
            r.value = neg ? (~q[OUT_WIDTH-1:0] + 1'b1) : q[OUT_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/complex_divide_unit.sv
// ----------------------------------------------------------------------------
// complex_divide_unit
// Pipelined complex divider, conjugate method, signed Q16.16 saturated output.
// ----------------------------------------------------------------------------
// Divides (num_re + j num_im) by (den_re + j den_im). One word is accepted
// per clock unless the pipeline stalls, and each result passes through one
// multiply stage, one sum stage, one magnitude stage, one range-check stage,
// 33 restoring-divide stages (one quotient bit each, run in parallel for the
// real and imaginary parts) and the output register. Every stage has its own
// valid bit and moves whenever the stage after it is empty or moving, so
// bubbles close up while a result waits at the output. A zero divisor gives
// zero quotients with o_div_by_zero set; a part outside the signed 32-bit
// range is clamped and sets o_overflow.
`default_nettype none

module complex_divide_unit
    import cdiv_pkg::*;
#(
    parameter int IN_WIDTH = 16,
    parameter int FRAC_OUT = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [IN_WIDTH-1:0]  i_num_re,
    input  logic signed [IN_WIDTH-1:0]  i_num_im,
    input  logic signed [IN_WIDTH-1:0]  i_den_re,
    input  logic signed [IN_WIDTH-1:0]  i_den_im,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [OUT_WIDTH-1:0] o_quot_re,
    output logic signed [OUT_WIDTH-1:0] o_quot_im,
    output logic                        o_div_by_zero,
    output logic                        o_overflow
);

    localparam int DW      = 2 * IN_WIDTH;
    localparam int RW      = DW + Q_BITS;
    localparam int NQ      = Q_BITS;
    localparam int ST_MUL  = 0;
    localparam int ST_SUM  = 1;
    localparam int ST_ABS  = 2;
    localparam int ST_CHK  = 3;
    localparam int ST_DIV  = 4;
    localparam int ST_OUT  = ST_DIV + NQ;
    localparam int NS      = ST_OUT + 1;

    logic [NS-1:0] r_vld;
    logic [NS:0]   w_en;

    assign w_en[NS] = i_out_ready;
    for (genvar s = 0; s < NS; s++) begin : g_en
        assign w_en[s] = ~r_vld[s] | w_en[s+1];
    end

    assign o_in_ready  = w_en[ST_MUL];
    assign o_out_valid = r_vld[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // products
    logic signed [DW-1:0] r_ac, r_bd, r_bc, r_ad, r_cc, r_dd;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MUL]) begin
            r_ac <= i_num_re * i_den_re;
            r_bd <= i_num_im * i_den_im;
            r_bc <= i_num_im * i_den_re;
            r_ad <= i_num_re * i_den_im;
            r_cc <= i_den_re * i_den_re;
            r_dd <= i_den_im * i_den_im;
        end
    end

    // conjugate numerators and squared modulus
    logic signed [DW:0]   r_re_sum, r_im_sum;
    logic        [DW-1:0] r_den_sum;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUM]) begin
            r_re_sum  <= {r_ac[DW-1], r_ac} + {r_bd[DW-1], r_bd};
            r_im_sum  <= {r_bc[DW-1], r_bc} - {r_ad[DW-1], r_ad};
            r_den_sum <= $unsigned(r_cc) + $unsigned(r_dd);
        end
    end

    // sign and magnitude
    logic [DW:0]   w_abs_re, w_abs_im;
    logic [DW-1:0] r_mag_re, r_mag_im, r_den_abs;
    t_flags        r_flg_abs;
    t_flags        n_flg_abs;

    assign w_abs_re = r_re_sum[DW] ? (~r_re_sum + 1'b1) : r_re_sum;
    assign w_abs_im = r_im_sum[DW] ? (~r_im_sum + 1'b1) : r_im_sum;

    always_comb begin
        n_flg_abs        = '0;
        n_flg_abs.neg_re = r_re_sum[DW];
        n_flg_abs.neg_im = r_im_sum[DW];
        n_flg_abs.dz     = (r_den_sum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_ABS]) begin
            r_mag_re  <= w_abs_re[DW-1:0];
            r_mag_im  <= w_abs_im[DW-1:0];
            r_den_abs <= r_den_sum;
            r_flg_abs <= n_flg_abs;
        end
    end

    // scale numerators; a quotient that needs more than Q_BITS bits is clamped
    logic [RW-1:0] w_num_re, w_num_im, w_den_top;
    logic [RW-1:0] r_num_re, r_num_im;
    logic [DW-1:0] r_den_chk;
    t_flags        r_flg_chk;
    t_flags        n_flg_chk;

    assign w_num_re  = RW'(r_mag_re) << FRAC_OUT;
    assign w_num_im  = RW'(r_mag_im) << FRAC_OUT;
    assign w_den_top = RW'(r_den_abs) << Q_BITS;

    always_comb begin
        n_flg_chk        = r_flg_abs;
        n_flg_chk.big_re = (w_num_re >= w_den_top);
        n_flg_chk.big_im = (w_num_im >= w_den_top);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_CHK]) begin
            r_num_re  <= w_num_re;
            r_num_im  <= w_num_im;
            r_den_chk <= r_den_abs;
            r_flg_chk <= n_flg_chk;
        end
    end

    // restoring divide, one quotient bit per stage, msb first
    logic [RW-1:0]     r_rem_re [NQ];
    logic [RW-1:0]     r_rem_im [NQ];
    logic [Q_BITS-1:0] r_q_re   [NQ];
    logic [Q_BITS-1:0] r_q_im   [NQ];
    logic [DW-1:0]     r_dv_den [NQ];
    t_flags            r_dv_flg [NQ];

    logic [RW-1:0]     s_rem_re [NQ+1];
    logic [RW-1:0]     s_rem_im [NQ+1];
    logic [Q_BITS-1:0] s_q_re   [NQ+1];
    logic [Q_BITS-1:0] s_q_im   [NQ+1];
    logic [DW-1:0]     s_den    [NQ+1];
    t_flags            s_flg    [NQ+1];

    assign s_rem_re[0] = r_num_re;
    assign s_rem_im[0] = r_num_im;
    assign s_q_re[0]   = '0;
    assign s_q_im[0]   = '0;
    assign s_den[0]    = r_den_chk;
    assign s_flg[0]    = r_flg_chk;

    for (genvar j = 0; j < NQ; j++) begin : g_div
        localparam int K = Q_BITS - 1 - j;

        logic [RW-1:0] w_dsh;
        logic          w_ge_re, w_ge_im;

        assign w_dsh   = RW'(s_den[j]) << K;
        assign w_ge_re = (s_rem_re[j] >= w_dsh);
        assign w_ge_im = (s_rem_im[j] >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (w_en[ST_DIV+j]) begin
                r_rem_re[j] <= w_ge_re ? (s_rem_re[j] - w_dsh) : s_rem_re[j];
                r_rem_im[j] <= w_ge_im ? (s_rem_im[j] - w_dsh) : s_rem_im[j];
                r_q_re[j]   <= s_q_re[j] | (Q_BITS'(w_ge_re) << K);
                r_q_im[j]   <= s_q_im[j] | (Q_BITS'(w_ge_im) << K);
                r_dv_den[j] <= s_den[j];
                r_dv_flg[j] <= s_flg[j];
            end
        end

        assign s_rem_re[j+1] = r_rem_re[j];
        assign s_rem_im[j+1] = r_rem_im[j];
        assign s_q_re[j+1]   = r_q_re[j];
        assign s_q_im[j+1]   = r_q_im[j];
        assign s_den[j+1]    = r_dv_den[j];
        assign s_flg[j+1]    = r_dv_flg[j];
    end

    // sign, clamp and output register
    t_part  w_part_re, w_part_im;
    t_flags w_flg_out;

    assign w_flg_out = s_flg[NQ];
    assign w_part_re = saturate(w_flg_out.neg_re, w_flg_out.big_re, s_q_re[NQ]);
    assign w_part_im = saturate(w_flg_out.neg_im, w_flg_out.big_im, s_q_im[NQ]);

    logic [OUT_WIDTH-1:0] r_quot_re, r_quot_im;
    logic                 r_dz, r_ovf;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            if (w_flg_out.dz) begin
                r_quot_re <= '0;
                r_quot_im <= '0;
                r_dz      <= 1'b1;
                r_ovf     <= 1'b0;
            end else begin
                r_quot_re <= w_part_re.value;
                r_quot_im <= w_part_im.value;
                r_dz      <= 1'b0;
                r_ovf     <= w_part_re.ovf | w_part_im.ovf;
            end
        end
    end

    assign o_quot_re     = r_quot_re;
    assign o_quot_im     = r_quot_im;
    assign o_div_by_zero = r_dz;
    assign o_overflow    = r_ovf;

endmodule

`default_nettype wire

FILE: rtl/core/cdiv_checker.sv
// ----------------------------------------------------------------------------
// cdiv_checker
// Port-level checks for the complex divider, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cdiv_checker
    import cdiv_pkg::*;
(
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic signed [OUT_WIDTH-1:0] o_quot_re,
    input logic signed [OUT_WIDTH-1:0] o_quot_im,
    input logic                        o_div_by_zero,
    input logic                        o_overflow
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_quot_re) &&
        $stable(o_quot_im) && $stable(o_div_by_zero) && $stable(o_overflow))
        else $error("result word changed while stalled");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_div_by_zero |->
        o_quot_re == '0 && o_quot_im == '0 && !o_overflow)
        else $error("zero divisor with nonzero quotient or overflow");

    a_ovf_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |->
        o_quot_re == OUT_MAX || o_quot_re == OUT_MIN ||
        o_quot_im == OUT_MAX || o_quot_im == OUT_MIN)
        else $error("overflow without a clamped quotient");

    // an empty output stage lets every stage move
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind complex_divide_unit cdiv_checker u_cdiv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_quot_re     (o_quot_re),
    .o_quot_im     (o_quot_im),
    .o_div_by_zero (o_div_by_zero),
    .o_overflow    (o_overflow)
);

`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for complex_divide_unit. A directed table covers zero divisors,
// operand extremes, exact and saturated quotients; random words follow under
// four flow-control phases. Every result word is checked field by field
// against a typed table value or else an exact conjugate-method integer model.
// ----------------------------------------------------------------------------
module tb;
    import cdiv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W           = 16;
    localparam int FRAC_BITS      = 16;
    localparam int RANDOM_BLOCKS  = 8;
    localparam int BLOCK_WORDS    = 144;
    localparam int DRAIN_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef enum int {
        FLOW_FREE,
        FLOW_SOURCE_IDLE,
        FLOW_SINK_STALL,
        FLOW_BOTH
    } t_flow;

    typedef struct {
        logic [OUT_WIDTH-1:0] re;
        logic [OUT_WIDTH-1:0] im;
        logic                 dz;
        logic                 ovf;
    } t_quotient;

    typedef struct {
        logic signed [IN_W-1:0] num_re;
        logic signed [IN_W-1:0] num_im;
        logic signed [IN_W-1:0] den_re;
        logic signed [IN_W-1:0] den_im;
        logic                   known;
        t_quotient              typed;
        t_flow                  mode;
    } t_word;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic signed [IN_W-1:0]      i_num_re;
    logic signed [IN_W-1:0]      i_num_im;
    logic signed [IN_W-1:0]      i_den_re;
    logic signed [IN_W-1:0]      i_den_im;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [OUT_WIDTH-1:0] o_quot_re;
    logic signed [OUT_WIDTH-1:0] o_quot_im;
    logic                        o_div_by_zero;
    logic                        o_overflow;

    t_word       word_q[$];
    t_quotient   quotient_q[$];
    t_flow       flow_now;
    int unsigned mismatch_count = 0;
    int unsigned result_count   = 0;
    int unsigned idle_cycles    = 0;

    always #4 i_clk = ~i_clk;

    complex_divide_unit #(
        .IN_WIDTH (IN_W),
        .FRAC_OUT (FRAC_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_num_re      (i_num_re),
        .i_num_im      (i_num_im),
        .i_den_re      (i_den_re),
        .i_den_im      (i_den_im),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_quot_re     (o_quot_re),
        .o_quot_im     (o_quot_im),
        .o_div_by_zero (o_div_by_zero),
        .o_overflow    (o_overflow)
    );

    // one quotient part: exact ratio scaled to Q16.16, truncated toward zero, clamped
    function automatic t_part scale_part(input longint num, input longint den);
        t_part  p;
        longint mag;
        mag = ((num < 0) ? -num : num) <<< FRAC_BITS;
        mag = mag / den;
        if (num < 0) begin
            p.ovf = (mag > 64'sh8000_0000);
        end else begin
            p.ovf = (mag > 64'sh7FFF_FFFF);
        end
        if (p.ovf) begin
            p.value = (num < 0) ? OUT_MIN : OUT_MAX;
        end else begin
            p.value = (num < 0) ? 32'(-mag) : 32'(mag);
        end
        return p;
    endfunction

    function automatic t_quotient predict_quotient(input logic signed [IN_W-1:0] a,
                                                   input logic signed [IN_W-1:0] b,
                                                   input logic signed [IN_W-1:0] c,
                                                   input logic signed [IN_W-1:0] d);
        t_quotient q;
        t_part     p_re;
        t_part     p_im;
        longint    den;
        den  = longint'(c) * longint'(c) + longint'(d) * longint'(d);
        q.dz = (den == 0);
        if (q.dz) begin
            q.re  = '0;
            q.im  = '0;
            q.ovf = 1'b0;
        end else begin
            p_re  = scale_part(longint'(a) * longint'(c) + longint'(b) * longint'(d), den);
            p_im  = scale_part(longint'(b) * longint'(c) - longint'(a) * longint'(d), den);
            q.re  = p_re.value;
            q.im  = p_im.value;
            q.ovf = p_re.ovf | p_im.ovf;
        end
        return q;
    endfunction

    task automatic add_word(input logic signed [IN_W-1:0] a, input logic signed [IN_W-1:0] b,
                            input logic signed [IN_W-1:0] c, input logic signed [IN_W-1:0] d,
                            input t_flow mode, input logic known,
                            input logic [OUT_WIDTH-1:0] re, input logic [OUT_WIDTH-1:0] im,
                            input logic dz, input logic ovf);
        t_word w;
        w.num_re    = a;
        w.num_im    = b;
        w.den_re    = c;
        w.den_im    = d;
        w.mode      = mode;
        w.known     = known;
        w.typed.re  = re;
        w.typed.im  = im;
        w.typed.dz  = dz;
        w.typed.ovf = ovf;
        word_q.push_back(w);
    endtask

    function automatic logic [IN_W-1:0] pick_operand(input int unsigned style);
        logic signed [IN_W-1:0] s;
        case (style)
            0: s = IN_W'($urandom);
            1: begin
                case ($urandom_range(5))
                    0: s = 16'sh8000;
                    1: s = 16'sh8001;
                    2: s = -16'sd1;
                    3: s = 16'sd0;
                    4: s = 16'sd1;
                    default: s = 16'sh7FFF;
                endcase
            end
            default: s = IN_W'($urandom_range(6)) - 16'sd3;
        endcase
        return s;
    endfunction

    function automatic logic source_gap(input t_flow mode);
        case (mode)
            FLOW_SOURCE_IDLE: return ($urandom_range(99) < 74);
            FLOW_BOTH:        return ($urandom_range(99) < 13);
            default:          return 1'b0;
        endcase
    endfunction

    initial begin : stimulus
        t_word                  held;
        logic signed [IN_W-1:0] a;
        logic signed [IN_W-1:0] b;
        logic signed [IN_W-1:0] c;
        logic signed [IN_W-1:0] d;
        int unsigned            kind;
        int unsigned            den_style;
        logic                   sending;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_num_re    <= '0;
        i_num_im    <= '0;
        i_den_re    <= '0;
        i_den_im    <= '0;
        i_out_ready <= 1'b0;
        flow_now    <= FLOW_FREE;
        sending     = 1'b0;

        // zero divisor
        add_word(0, 0, 0, 0, FLOW_FREE, 1, 0, 0, 1, 0);
        add_word(32767, -32768, 0, 0, FLOW_FREE, 1, 0, 0, 1, 0);
        add_word(-32768, -32768, 0, 0, FLOW_FREE, 1, 0, 0, 1, 0);
        // exact quotients and the representable negative limit
        add_word(32767, 0, 32767, 0, FLOW_FREE, 1, 32'h0001_0000, 0, 0, 0);
        add_word(-32768, 0, 1, 0, FLOW_FREE, 1, OUT_MIN, 0, 0, 0);
        add_word(32767, 0, 1, 0, FLOW_FREE, 1, 32'h7FFF_0000, 0, 0, 0);
        add_word(-32768, 0, 0, -1, FLOW_FREE, 1, 0, OUT_MIN, 0, 0);
        add_word(0, 0, 5, 3, FLOW_FREE, 1, 0, 0, 0, 0);
        // positive saturation on both parts, on the real part alone, on the imaginary alone
        add_word(-32768, -32768, -1, 0, FLOW_FREE, 1, OUT_MAX, OUT_MAX, 0, 1);
        add_word(0, -32768, 0, -1, FLOW_FREE, 1, OUT_MAX, 0, 0, 1);
        add_word(-32768, 0, 0, 1, FLOW_FREE, 1, 0, OUT_MAX, 0, 1);
        // truncation toward zero, large divisors, mixed signs
        add_word(1, 0, 3, 0, FLOW_FREE, 0, 0, 0, 0, 0);
        add_word(-1, 0, 3, 0, FLOW_FREE, 0, 0, 0, 0, 0);
        add_word(1, -1, 32767, 32767, FLOW_FREE, 0, 0, 0, 0, 0);
        add_word(32767, 32767, -32768, -32768, FLOW_FREE, 0, 0, 0, 0, 0);
        add_word(-32768, 32767, 32767, -32768, FLOW_FREE, 0, 0, 0, 0, 0);
        add_word(1, 1, -32768, 0, FLOW_FREE, 0, 0, 0, 0, 0);
        add_word(-1, -1, 1, 1, FLOW_FREE, 0, 0, 0, 0, 0);
        add_word(-32768, -32768, 1, 1, FLOW_FREE, 0, 0, 0, 0, 0);
        add_word(32767, 32767, 1, -1, FLOW_FREE, 0, 0, 0, 0, 0);
        add_word(12345, -23456, -3, 7, FLOW_FREE, 0, 0, 0, 0, 0);
        add_word(-32768, 0, -1, -1, FLOW_FREE, 0, 0, 0, 0, 0);

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            for (int n = 0; n < BLOCK_WORDS; n++) begin
                kind = $urandom_range(99);
                a    = pick_operand(($urandom_range(3) == 0) ? 1 : 0);
                b    = pick_operand(($urandom_range(3) == 0) ? 1 : 0);
                if (kind < 4) begin
                    c = '0;
                    d = '0;
                end else if (kind < 14) begin
                    // unit divisors with extreme dividends reach the clamp
                    a = pick_operand(1);
                    b = pick_operand(1);
                    case ($urandom_range(3))
                        0: begin c = 16'sd1;  d = 16'sd0;  end
                        1: begin c = -16'sd1; d = 16'sd0;  end
                        2: begin c = 16'sd0;  d = 16'sd1;  end
                        default: begin c = 16'sd0; d = -16'sd1; end
                    endcase
                end else begin
                    den_style = $urandom_range(9);
                    c = pick_operand((den_style < 5) ? 0 : (den_style < 8) ? 2 : 1);
                    d = pick_operand((den_style < 5) ? 0 : (den_style < 8) ? 2 : 1);
                end
                add_word(a, b, c, d, t_flow'(blk % 4), 0, 0, 0, 0, 0);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sending follows the driven valid without waiting for the update
        while (word_q.size() > 0 || sending) begin
            @(posedge i_clk);
            if (i_in_valid && o_in_ready) begin
                quotient_q.push_back(held.known ? held.typed :
                    predict_quotient(held.num_re, held.num_im, held.den_re, held.den_im));
            end
            if (!i_in_valid || o_in_ready) begin
                if (word_q.size() > 0 && !source_gap(word_q[0].mode)) begin
                    held = word_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_num_re   <= held.num_re;
                    i_num_im   <= held.num_im;
                    i_den_re   <= held.den_re;
                    i_den_im   <= held.den_im;
                    flow_now   <= held.mode;
                    sending    = 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                    sending    = 1'b0;
                end
            end
        end

        while (quotient_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        case (flow_now)
            FLOW_SINK_STALL: i_out_ready <= ($urandom_range(99) >= 74);
            FLOW_BOTH:       i_out_ready <= ($urandom_range(99) >= 13);
            default:         i_out_ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin : check_results
        t_quotient want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            result_count++;
            if (quotient_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("result word %0d with none pending: re %h im %h dz %b ovf %b",
                             result_count, o_quot_re, o_quot_im, o_div_by_zero, o_overflow);
                end
            end else begin
                want = quotient_q.pop_front();
                if (o_quot_re !== want.re || o_quot_im !== want.im ||
                    o_div_by_zero !== want.dz || o_overflow !== want.ovf) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("result word %0d: re exp %h got %h, im exp %h got %h",
                                 result_count, want.re, o_quot_re, want.im, o_quot_im);
                        $display("    dz exp %b got %b, ovf exp %b got %b",
                                 want.dz, o_div_by_zero, want.ovf, o_overflow);
                    end
                end
            end
        end
    end

    // a stuck handshake ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
